@@ rtl/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg
// Types and constants shared by the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam logic [1:0] CFG_TEMP_COEFFS = 2'd0;
    localparam logic [1:0] CFG_PRESS_LOW   = 2'd1;
    localparam logic [1:0] CFG_PRESS_HIGH  = 2'd2;
    localparam logic [1:0] CFG_PRESS_NINE  = 2'd3;

    localparam logic signed [25:0] FINE_OFFSET = 26'sd128000;
    localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
    localparam logic [63:0]        PRESS_SCALE = 64'd3125;

    typedef struct packed {
        logic [19:0] adc_t;
        logic [19:0] adc_p;
    } t_in;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               divisor_zero;
    } t_out;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_cal;

endpackage

@@ rtl/ptc_mul.sv @@
// ----------------------------------------------------------------------------
// ptc_mul
// Two-stage 64x64 multiplier returning the low 64 bits of the product.
// ----------------------------------------------------------------------------
module ptc_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;
    logic [63:0] n_ll;
    logic [31:0] n_lh;
    logic [31:0] n_hl;
    logic [31:0] n_cross;

    always_comb begin
        n_ll    = {32'd0, i_a[31:0]} * {32'd0, i_b[31:0]};
        n_lh    = i_a[31:0] * i_b[63:32];
        n_hl    = i_a[63:32] * i_b[31:0];
        n_cross = r_lh + r_hl;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hl <= n_hl;
            r_p  <= r_ll + {n_cross, 32'd0};
        end
    end

    assign o_p = r_p;

endmodule

@@ rtl/ptc_front.sv @@
// ----------------------------------------------------------------------------
// ptc_front
// Temperature, fine term, pressure divisor and dividend (ten stages).
// ----------------------------------------------------------------------------
module ptc_front import ptc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_in                i_data,
    input  t_cal               i_cal,
    output logic               o_valid,
    output logic [63:0]        o_num,
    output logic signed [30:0] o_div,
    output logic signed [31:0] o_temp
);

    logic [9:0] r_vld;

    logic signed [17:0] n1_d1;
    logic signed [16:0] n1_d2;
    logic signed [33:0] n1_d1t2;
    logic signed [33:0] n1_dd;
    logic signed [33:0] r1_d1t2;
    logic [31:0]        r1_dd;
    logic [19:0]        r1_adc_p;

    logic signed [36:0] n2_a2m;
    logic signed [22:0] r2_a1;
    logic signed [36:0] r2_a2m;
    logic [19:0]        r2_adc_p;

    logic signed [24:0] r3_fine;
    logic [19:0]        r3_adc_p;

    logic signed [25:0] n4_v1;
    logic signed [51:0] n4_sq;
    logic signed [41:0] n4_vp5;
    logic signed [41:0] n4_vp2;
    logic signed [28:0] n4_t5;
    logic [63:0]        r4_sq;
    logic signed [41:0] r4_vp5;
    logic signed [41:0] r4_vp2;
    logic signed [31:0] r4_temp;
    logic [19:0]        r4_adc_p;

    logic signed [41:0] r5_vp5;
    logic signed [41:0] r5_vp2;
    logic signed [31:0] r5_temp;
    logic [19:0]        r5_adc_p;
    logic signed [41:0] r6_vp5;
    logic signed [41:0] r6_vp2;
    logic signed [31:0] r6_temp;
    logic [19:0]        r6_adc_p;

    logic [63:0]        w_sp6;
    logic [63:0]        w_sp3;
    logic [63:0]        n7_v1b;
    logic [63:0]        r7_v2;
    logic [63:0]        r7_x;
    logic signed [31:0] r7_temp;
    logic [19:0]        r7_adc_p;

    logic [20:0]        n8_pp;
    logic [63:0]        r8_num;
    logic [63:0]        r8_x;
    logic signed [31:0] r8_temp;
    logic signed [31:0] r9_temp;
    logic signed [31:0] r10_temp;

    logic [63:0]        w_pn;
    logic [63:0]        w_px;

    always_comb begin
        n1_d1   = $signed({1'b0, i_data.adc_t[19:3]}) - $signed({1'b0, i_cal.t1, 1'b0});
        n1_d2   = $signed({1'b0, i_data.adc_t[19:4]}) - $signed({1'b0, i_cal.t1});
        n1_d1t2 = n1_d1 * i_cal.t2;
        n1_dd   = n1_d2 * n1_d2;
        n2_a2m  = $signed({1'b0, r1_dd[31:12]}) * i_cal.t3;
        n4_v1   = 26'(r3_fine) - FINE_OFFSET;
        n4_sq   = n4_v1 * n4_v1;
        n4_vp5  = n4_v1 * i_cal.p5;
        n4_vp2  = n4_v1 * i_cal.p2;
        n4_t5   = (29'(r3_fine) <<< 2) + 29'(r3_fine) + 29'sd128;
        n7_v1b  = 64'($signed(w_sp3) >>> 8) + (64'(r6_vp2) << 12);
        n8_pp   = PRESS_FULL - {1'b0, r7_adc_p};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[8:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d1t2  <= n1_d1t2;
            r1_dd    <= n1_dd[31:0];
            r1_adc_p <= i_data.adc_p;

            r2_a1    <= 23'(r1_d1t2 >>> 11);
            r2_a2m   <= n2_a2m;
            r2_adc_p <= r1_adc_p;

            r3_fine  <= 25'(r2_a1) + 25'(r2_a2m >>> 14);
            r3_adc_p <= r2_adc_p;

            r4_sq    <= 64'(n4_sq);
            r4_vp5   <= n4_vp5;
            r4_vp2   <= n4_vp2;
            r4_temp  <= 32'(n4_t5 >>> 8);
            r4_adc_p <= r3_adc_p;

            r5_vp5   <= r4_vp5;
            r5_vp2   <= r4_vp2;
            r5_temp  <= r4_temp;
            r5_adc_p <= r4_adc_p;
            r6_vp5   <= r5_vp5;
            r6_vp2   <= r5_vp2;
            r6_temp  <= r5_temp;
            r6_adc_p <= r5_adc_p;

            r7_v2    <= w_sp6 + (64'(r6_vp5) << 17) + (64'(i_cal.p4) << 35);
            r7_x     <= n7_v1b + (64'd1 << 47);
            r7_temp  <= r6_temp;
            r7_adc_p <= r6_adc_p;

            r8_num   <= ({43'd0, n8_pp} << 31) - r7_v2;
            r8_x     <= r7_x;
            r8_temp  <= r7_temp;

            r9_temp  <= r8_temp;
            r10_temp <= r9_temp;
        end
    end

    ptc_mul u_mul_p6 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r4_sq),
        .i_b   (64'(i_cal.p6)),
        .o_p   (w_sp6)
    );

    ptc_mul u_mul_p3 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r4_sq),
        .i_b   (64'(i_cal.p3)),
        .o_p   (w_sp3)
    );

    ptc_mul u_mul_p1 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r8_x),
        .i_b   ({48'd0, i_cal.p1}),
        .o_p   (w_px)
    );

    ptc_mul u_mul_scale (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r8_num),
        .i_b   (PRESS_SCALE),
        .o_p   (w_pn)
    );

    assign o_valid = r_vld[9];
    assign o_num   = w_pn;
    assign o_div   = $signed(w_px[63:33]);
    assign o_temp  = r10_temp;

endmodule

@@ rtl/ptc_div.sv @@
// ----------------------------------------------------------------------------
// ptc_div
// Signed 64 / 31-bit divider, truncating, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [63:0]        i_num,
    input  logic signed [30:0] i_div,
    input  logic signed [31:0] i_temp,
    output logic               o_valid,
    output logic [63:0]        o_quo,
    output logic               o_zero,
    output logic signed [31:0] o_temp
);

    localparam int NSTEP = 64;

    typedef struct packed {
        logic [30:0]        rem;
        logic [63:0]        dq;
        logic [30:0]        mb;
        logic               neg;
        logic               zero;
        logic signed [31:0] temp;
    } t_dst;

    function automatic t_dst f_step(t_dst s);
        logic [31:0] cand;
        t_dst        r;
        cand = {s.rem, s.dq[63]};
        r    = s;
        if (cand >= {1'b0, s.mb}) begin
            r.rem = 31'(cand - {1'b0, s.mb});
            r.dq  = {s.dq[62:0], 1'b1};
        end else begin
            r.rem = cand[30:0];
            r.dq  = {s.dq[62:0], 1'b0};
        end
        return r;
    endfunction

    logic [NSTEP+1:0]   r_vld;
    t_dst               r_st [0:NSTEP];
    t_dst               n_prep;
    logic [63:0]        r_quo;
    logic               r_zero;
    logic signed [31:0] r_temp;

    always_comb begin
        n_prep.rem  = '0;
        n_prep.dq   = i_num[63] ? (64'd0 - i_num) : i_num;
        n_prep.mb   = i_div[30] ? (31'd0 - i_div) : i_div;
        n_prep.neg  = i_num[63] ^ i_div[30];
        n_prep.zero = (i_div == '0);
        n_prep.temp = i_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTEP:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_prep;
        end
    end

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k+1] <= f_step(r_st[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo  <= r_st[NSTEP].neg ? (64'd0 - r_st[NSTEP].dq) : r_st[NSTEP].dq;
            r_zero <= r_st[NSTEP].zero;
            r_temp <= r_st[NSTEP].temp;
        end
    end

    assign o_valid = r_vld[NSTEP+1];
    assign o_quo   = r_quo;
    assign o_zero  = r_zero;
    assign o_temp  = r_temp;

endmodule

@@ rtl/ptc_back.sv @@
// ----------------------------------------------------------------------------
// ptc_back
// Second-order pressure correction after the division (six stages).
// ----------------------------------------------------------------------------
module ptc_back import ptc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [63:0]        i_p,
    input  logic               i_zero,
    input  logic signed [31:0] i_temp,
    input  t_cal               i_cal,
    output logic               o_valid,
    output t_out               o_data
);

    logic [5:0]         r_vld;

    logic [63:0]        w_s;
    logic [63:0]        w_ss;
    logic [63:0]        w_pp8;
    logic [63:0]        w_pss9;

    logic [63:0]        ra1_p;
    logic               ra1_zero;
    logic signed [31:0] ra1_temp;
    logic [63:0]        ra2_p;
    logic               ra2_zero;
    logic signed [31:0] ra2_temp;

    logic [63:0]        rb1_p;
    logic [63:0]        rb1_w2;
    logic               rb1_zero;
    logic signed [31:0] rb1_temp;
    logic [63:0]        rb2_p;
    logic [63:0]        rb2_w2;
    logic               rb2_zero;
    logic signed [31:0] rb2_temp;

    logic [63:0]        r5_sum;
    logic               r5_zero;
    logic signed [31:0] r5_temp;

    logic [63:0]        n_pr;
    t_out               r_out;

    always_comb begin
        w_s  = 64'($signed(i_p) >>> 13);
        n_pr = 64'($signed(r5_sum) >>> 8) + (64'(i_cal.p7) << 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra1_p    <= i_p;
            ra1_zero <= i_zero;
            ra1_temp <= i_temp;
            ra2_p    <= ra1_p;
            ra2_zero <= ra1_zero;
            ra2_temp <= ra1_temp;

            rb1_p    <= ra2_p;
            rb1_w2   <= 64'($signed(w_pp8) >>> 19);
            rb1_zero <= ra2_zero;
            rb1_temp <= ra2_temp;
            rb2_p    <= rb1_p;
            rb2_w2   <= rb1_w2;
            rb2_zero <= rb1_zero;
            rb2_temp <= rb1_temp;

            r5_sum   <= rb2_p + 64'($signed(w_pss9) >>> 25) + rb2_w2;
            r5_zero  <= rb2_zero;
            r5_temp  <= rb2_temp;

            r_out.temperature_centi <= r5_temp;
            r_out.pressure_q24_8    <= r5_zero ? 32'd0 : n_pr[31:0];
            r_out.divisor_zero      <= r5_zero;
        end
    end

    ptc_mul u_mul_sq (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_s),
        .i_b   (w_s),
        .o_p   (w_ss)
    );

    ptc_mul u_mul_p8 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_p),
        .i_b   (64'(i_cal.p8)),
        .o_p   (w_pp8)
    );

    ptc_mul u_mul_p9 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_ss),
        .i_b   (64'(i_cal.p9)),
        .o_p   (w_pss9)
    );

    assign o_valid = r_vld[5];
    assign o_data  = r_out;

endmodule

@@ rtl/pressure_temperature_compensation.sv @@
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Integer compensation of raw barometric temperature and pressure readings.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (i_in_valid / o_in_ready) carries one raw adc_t / adc_p pair.
//   Output beat (o_out_valid / i_out_ready) carries temperature in 0.01 degC,
//   pressure in Pa as Q24.8 and the zero-divisor flag, one per input beat.
//   Calibration words are written through i_cfg_we / i_cfg_index /
//   i_cfg_data while no beat is in flight; they reset to zero.
//   Throughput: one beat per cycle unless both output entries are full.
//   Each beat passes the 64-stage radix-2 divider and the multiplier
//   stages around it on its way from input accept to o_out_valid.
//   Reset clears all valid bits and the calibration registers.
//   When the receiver stalls, a two-entry output buffer absorbs the beat in
//   flight; the pipeline freezes only once both entries are full, and
//   o_in_ready drops with it. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation import ptc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [47:0]        r_temp_coeffs;
    logic [63:0]        r_press_low;
    logic [63:0]        r_press_high;
    logic [15:0]        r_press_nine;
    t_cal               w_cal;

    logic               w_en;
    logic               w_f_valid;
    logic [63:0]        w_f_num;
    logic signed [30:0] w_f_div;
    logic signed [31:0] w_f_temp;
    logic               w_d_valid;
    logic [63:0]        w_d_quo;
    logic               w_d_zero;
    logic signed [31:0] w_d_temp;
    logic               w_b_valid;
    t_out               w_b_data;

    logic               r_out_v;
    t_out               r_out;
    logic               r_skid_v;
    t_out               r_skid;
    logic               w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_low   <= '0;
            r_press_high  <= '0;
            r_press_nine  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEMP_COEFFS: r_temp_coeffs <= i_cfg_data[47:0];
                CFG_PRESS_LOW:   r_press_low   <= i_cfg_data;
                CFG_PRESS_HIGH:  r_press_high  <= i_cfg_data;
                CFG_PRESS_NINE:  r_press_nine  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cal.t1 = r_temp_coeffs[15:0];
        w_cal.t2 = $signed(r_temp_coeffs[31:16]);
        w_cal.t3 = $signed(r_temp_coeffs[47:32]);
        w_cal.p1 = r_press_low[15:0];
        w_cal.p2 = $signed(r_press_low[31:16]);
        w_cal.p3 = $signed(r_press_low[47:32]);
        w_cal.p4 = $signed(r_press_low[63:48]);
        w_cal.p5 = $signed(r_press_high[15:0]);
        w_cal.p6 = $signed(r_press_high[31:16]);
        w_cal.p7 = $signed(r_press_high[47:32]);
        w_cal.p8 = $signed(r_press_high[63:48]);
        w_cal.p9 = $signed(r_press_nine);
    end

    assign w_en       = !r_skid_v;
    assign w_out_free = !r_out_v || i_out_ready;

    ptc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cal   (w_cal),
        .o_valid (w_f_valid),
        .o_num   (w_f_num),
        .o_div   (w_f_div),
        .o_temp  (w_f_temp)
    );

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_num   (w_f_num),
        .i_div   (w_f_div),
        .i_temp  (w_f_temp),
        .o_valid (w_d_valid),
        .o_quo   (w_d_quo),
        .o_zero  (w_d_zero),
        .o_temp  (w_d_temp)
    );

    ptc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_valid),
        .i_p     (w_d_quo),
        .i_zero  (w_d_zero),
        .i_temp  (w_d_temp),
        .i_cal   (w_cal),
        .o_valid (w_b_valid),
        .o_data  (w_b_data)
    );

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_out_free) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (w_b_valid) begin
            if (w_out_free) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_out_free) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_out_free) begin
                r_out <= r_skid;
            end
        end else if (w_b_valid) begin
            if (w_out_free) begin
                r_out <= w_b_data;
            end else begin
                r_skid <= w_b_data;
            end
        end
    end

    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_out_ready))
        else $error("skid entry filled without a stalled output");

    a_zero_forces_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.divisor_zero) |-> (o_out_data.pressure_q24_8 == 32'd0))
        else $error("zero divisor with nonzero pressure");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the barometric compensation block against a behavioral predictor.
// A directed table exercises input and calibration extremes and the zero
// divisor case; random beats, mostly bursty and with output stalls, follow.
// ----------------------------------------------------------------------------
module tb;
    import ptc_pkg::*;

    localparam int LATENCY    = 83;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM   = 1800;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    pressure_temperature_compensation u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [63:0] cal_temp, cal_plow, cal_phigh, cal_p9;
    t_out        pending_q[$];
    int          n_errors = 0;
    int          n_results = 0;
    int          n_zero = 0;
    int          idle_cycles = 0;
    bit          stall_en = 1'b1;

    typedef struct {
        logic [19:0] adc_t;
        logic [19:0] adc_p;
        bit          known;
        t_out        res;
    } t_row;

    function automatic logic [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic t_out compensate(logic [19:0] adc_t, logic [19:0] adc_p);
        logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] d1, a1, d2, a2, fine, temp, v1, v2, p, w1, w2, pr, ma, mb, q;
        t_out r;
        t1 = {48'd0, cal_temp[15:0]};
        t2 = sx16(cal_temp[31:16]);
        t3 = sx16(cal_temp[47:32]);
        p1 = {48'd0, cal_plow[15:0]};
        p2 = sx16(cal_plow[31:16]);
        p3 = sx16(cal_plow[47:32]);
        p4 = sx16(cal_plow[63:48]);
        p5 = sx16(cal_phigh[15:0]);
        p6 = sx16(cal_phigh[31:16]);
        p7 = sx16(cal_phigh[47:32]);
        p8 = sx16(cal_phigh[63:48]);
        p9 = sx16(cal_p9[15:0]);
        d1 = {44'd0, adc_t} >> 3;
        d1 = d1 - (t1 << 1);
        a1 = asr64(d1 * t2, 11);
        d2 = ({44'd0, adc_t} >> 4) - t1;
        a2 = asr64(asr64(d2 * d2, 12) * t3, 14);
        fine = a1 + a2;
        temp = asr64(fine * 64'd5 + 64'd128, 8);
        v1 = fine - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
        pr = '0;
        if (v1 != 0) begin
            p = 64'd1048576 - {44'd0, adc_p};
            p = ((p << 31) - v2) * 64'd3125;
            ma = p[63] ? -p : p;
            mb = v1[63] ? -v1 : v1;
            q = ma / mb;
            p = (p[63] != v1[63]) ? -q : q;
            w1 = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
            w2 = asr64(p8 * p, 19);
            pr = asr64(p + w1 + w2, 8) + (p7 << 4);
        end
        r.temperature_centi = temp[31:0];
        r.pressure_q24_8    = pr[31:0];
        r.divisor_zero      = (v1 == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, t_out got, t_out want);
        n_errors++;
        $display("mismatch %s: got t=%0d p=%0h z=%0b want t=%0d p=%0h z=%0b", what,
                 got.temperature_centi, got.pressure_q24_8, got.divisor_zero,
                 want.temperature_centi, want.pressure_q24_8, want.divisor_zero);
    endtask

    // result checker, receiver stall pattern and watchdog
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (o_out_data.divisor_zero) n_zero++;
                if (pending_q.size() == 0) begin
                    report_mismatch("unexpected beat", o_out_data, '0);
                end else begin
                    want = pending_q.pop_front();
                    if (o_out_data.temperature_centi !== want.temperature_centi)
                        report_mismatch("temperature", o_out_data, want);
                    else if (o_out_data.pressure_q24_8 !== want.pressure_q24_8)
                        report_mismatch("pressure", o_out_data, want);
                    else if (o_out_data.divisor_zero !== want.divisor_zero)
                        report_mismatch("divisor flag", o_out_data, want);
                end
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("watchdog expired");
                $display("FAILED: results differ");
                $finish;
            end
        end
        i_out_ready <= !stall_en || (($urandom_range(0, 15) > 4) ^ (n_results % 97 < 6));
    end

    task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_TEMP_COEFFS: cal_temp  = val & 64'hFFFF_FFFF_FFFF;
            CFG_PRESS_LOW:   cal_plow  = val;
            CFG_PRESS_HIGH:  cal_phigh = val;
            default:         cal_p9    = val & 64'hFFFF;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_cal(logic [63:0] t, logic [63:0] lo, logic [63:0] hi,
                           logic [63:0] nine);
        cfg_write(CFG_TEMP_COEFFS, t);
        cfg_write(CFG_PRESS_LOW, lo);
        cfg_write(CFG_PRESS_HIGH, hi);
        cfg_write(CFG_PRESS_NINE, nine);
    endtask

    task automatic drain;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // one beat; valid stays high across back-to-back beats
    task automatic send(logic [19:0] t, logic [19:0] p, bit known, t_out res);
        i_in_valid <= 1'b1;
        i_in_data  <= '{adc_t: t, adc_p: p};
        do @(posedge i_clk); while (!o_in_ready);
        pending_q.push_back(known ? res : compensate(t, p));
    endtask

    task automatic send_random(int n, bit bursty);
        int left;
        left = $urandom_range(1, 40);
        for (int k = 0; k < n; k++) begin
            send(20'($urandom()), 20'($urandom()), 1'b0, '0);
            if (bursty && --left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                left = $urandom_range(1, 40);
            end
        end
        i_in_valid <= 1'b0;
    endtask

    t_row dir_tab[] = '{
        '{20'h00000, 20'h00000, 1'b1, '{32'sd0, 32'd0, 1'b1}},
        '{20'hFFFFF, 20'hFFFFF, 1'b1, '{32'sd0, 32'd0, 1'b1}},
        '{20'h00000, 20'hFFFFF, 1'b0, '0},
        '{20'hFFFFF, 20'h00000, 1'b0, '0},
        '{20'h80000, 20'h80000, 1'b0, '0},
        '{20'h7FFFF, 20'h7FFFF, 1'b0, '0},
        '{20'h00001, 20'h00001, 1'b0, '0},
        '{20'h82D60, 20'h65E3B, 1'b0, '0}
    };

    initial begin
        cal_temp = '0; cal_plow = '0; cal_phigh = '0; cal_p9 = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset calibration: divisor is zero, temperature is zero
        for (int k = 0; k < 2; k++)
            send(dir_tab[k].adc_t, dir_tab[k].adc_p, 1'b1, dir_tab[k].res);
        i_in_valid <= 1'b0;
        drain();

        // typical datasheet calibration
        set_cal({16'hFC18, 16'h6770, 16'h6E50},
                {16'h2710, 16'h0BD0, 16'hD5A1, 16'h8E1C},
                {16'hFFE8, 16'h1770, 16'hFF83, 16'h008C}, 64'h1770);
        foreach (dir_tab[k]) send(dir_tab[k].adc_t, dir_tab[k].adc_p, 1'b0, '0);
        i_in_valid <= 1'b0;
        drain();

        // all-ones and sign-extreme calibrations
        set_cal('1, '1, '1, '1);
        foreach (dir_tab[k]) send(dir_tab[k].adc_t, dir_tab[k].adc_p, 1'b0, '0);
        i_in_valid <= 1'b0;
        drain();
        set_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF},
                {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 64'h8000);
        foreach (dir_tab[k]) send(dir_tab[k].adc_t, dir_tab[k].adc_p, 1'b0, '0);
        i_in_valid <= 1'b0;
        drain();

        // random beats; random calibrations bar the last; one phase unstalled
        for (int ph = 0; ph < 6; ph++) begin
            stall_en = (ph != 2);
            if (ph == 5)
                set_cal({16'hFC18, 16'h6770, 16'h6E50},
                        {16'h2710, 16'h0BD0, 16'hD5A1, 16'h8E1C},
                        {16'hFFE8, 16'h1770, 16'hFF83, 16'h008C}, 64'h1770);
            else
                set_cal({$urandom(), $urandom()}, {$urandom(), $urandom()},
                        {$urandom(), $urandom()}, {$urandom(), $urandom()});
            send_random(N_RANDOM / 12, ph != 2);
            // hold off until every result is back, then continue
            while (pending_q.size() != 0) @(posedge i_clk);
            send_random(N_RANDOM / 12, 1'b1);
            drain();
        end

        $display("covered %0d results, %0d with zero divisor, over 10 calibrations",
                 n_results, n_zero);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
